// ===== sv/sgb11_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb11_pkg
// Shared constants and types of the 11-tap separable Gaussian blur unit.
// ----------------------------------------------------------------------------
package sgb11_pkg;

    localparam int TAPS = 11;
    localparam int HALF = 5;
    localparam int LINES = 10;
    localparam int PIX_W = 8;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration port
    localparam int FW_W = 11;
    localparam int FH_W = 13;
    localparam int CFG_W = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // q16 weights, sum is 65536
    localparam int COEF_W = 15;
    localparam logic [COEF_W-1:0] GAUSS_W [TAPS] = '{
        15'd67, 15'd498, 15'd2360, 15'd7167, 15'd13959, 15'd17434,
        15'd13959, 15'd7167, 15'd2360, 15'd498, 15'd67
    };
    localparam int ACC_W = 25;
    localparam logic [ACC_W-1:0] ROUND_HALF = 25'd32768;

    // exact divide by ten for 16-bit values
    localparam logic [31:0] DIV10_MUL = 32'd52429;
    localparam int DIV10_SHIFT = 19;

    // exact divide by eleven for 13-bit values
    localparam logic [31:0] DIV11_MUL = 32'd95326;
    localparam int DIV11_SHIFT = 20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_VERT
    } state_t;

endpackage

// ===== sv/separable_gaussian_blur_11tap_unit.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_11tap_unit
// Streaming 11x11 Gaussian blur of an 8-bit raster frame with edge clamping.
// ----------------------------------------------------------------------------
// Pixels enter in raster order; each result carries its column and row and
// leaves as soon as its clamped window is complete, so the output lags the
// input by five rows and five columns and flushes at row and frame ends.
// The ten previous rows of horizontal results sit in one line memory with a
// word per column (ten bytes wide); every filtered column costs one read and
// one write-back of that word. An input that finishes no column leaves the
// unit idle; for each column that it finishes, the unit reads the line word,
// filters that column's finished rows in turn, holding on any output stall,
// and writes the word back; in_ready is low meanwhile. The line memory is
// not cleared after reset: a frame must arrive whole. The user must write
// frame size only while the unit is idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_11tap_unit #(
    parameter int MAX_WIDTH = sgb11_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sgb11_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sgb11_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sgb11_pkg::CFG_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sgb11_pkg::PIX_W-1:0]       pixel_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sgb11_pkg::PIX_W-1:0]       blurred_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]      out_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]     out_row,
    output logic                              last_of_burst,
    output logic                              frame_done
);
    import sgb11_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    state_t state_reg, state_next;

    logic [FW_W-1:0] fw_reg;
    logic [FH_W-1:0] fh_reg;
    logic [CW-1:0] col_cnt_reg;
    logic [RW-1:0] row_cnt_reg;
    logic [TAPS-1:0][PIX_W-1:0] win_reg;

    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic c_end_reg, r_end_reg, have_y_reg;
    logic [2:0] m_reg, n_reg, n_init_reg;
    logic [3:0] slot_reg;
    logic [3:0] c_slot_reg;
    logic [PIX_W-1:0] hv_reg;

    logic [LINES-1:0][PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [LINES-1:0][PIX_W-1:0] rd_data_reg;

    logic out_valid_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic out_last_reg, out_done_reg;

    // clamped position of the arriving pixel
    logic [CW-1:0] last_col, c_in;
    logic [RW-1:0] last_row, r_in;
    logic c_end, r_end, c_ge, r_ge, have_x;
    logic [2:0] m_init, n_init;
    logic [31:0] quot11;
    logic [3:0] c_slot;

    logic accept, out_free, step, x_done, emit, mem_rd_en, mem_wr_en;
    logic last_x, last_y;
    logic [CW-1:0] x_cur;
    logic [RW-1:0] y_cur;
    logic [PIX_W-1:0] hv, vout;
    logic [3:0] row_slot;
    logic [31:0] quot;
    logic [LINES-1:0][PIX_W-1:0] wr_row;

    always_comb
    begin
        if (fw_reg == '0)
            last_col = '0;
        else if (32'(fw_reg) > MAX_W32)
            last_col = CW'(MAX_W32 - 32'd1);
        else
            last_col = CW'(32'(fw_reg) - 32'd1);
        if (fh_reg == '0)
            last_row = '0;
        else if (32'(fh_reg) > MAX_H32)
            last_row = RW'(MAX_H32 - 32'd1);
        else
            last_row = RW'(32'(fh_reg) - 32'd1);
        c_in = (col_cnt_reg < last_col) ? col_cnt_reg : last_col;
        r_in = (row_cnt_reg < last_row) ? row_cnt_reg : last_row;
        c_end = (c_in == last_col);
        r_end = (r_in == last_row);
        c_ge = (c_in >= CW'(HALF));
        r_ge = (r_in >= RW'(HALF));
        have_x = c_end || c_ge;
        m_init = (c_end && !c_ge) ? c_in[2:0] : 3'(HALF);
        n_init = (r_end && !r_ge) ? r_in[2:0] : 3'(HALF);
    end

    // window slot of the arriving pixel, column mod eleven by reciprocal
    always_comb
    begin
        quot11 = (32'(c_in) * DIV11_MUL) >> DIV11_SHIFT;
        c_slot = 4'(32'(c_in) - ((quot11 << 3) + (quot11 << 1) + quot11));
    end

    // control outputs of the sequencer
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        accept = in_valid && in_ready;
        out_free = !out_valid_reg || out_ready;
        // only the row or frame end flushes more than one column or row
        last_x = (m_reg == '0) || !c_end_reg;
        last_y = (n_reg == '0) || !r_end_reg;
        step = (state_reg == ST_VERT) && (!have_y_reg || out_free);
        x_done = step && (!have_y_reg || last_y);
        emit = (state_reg == ST_VERT) && have_y_reg && out_free;
        mem_rd_en = (state_reg == ST_READ);
        mem_wr_en = (state_reg == ST_VERT) && x_done;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && have_x)
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_VERT;
            ST_VERT:
            begin
                if (x_done)
                    state_next = last_x ? ST_IDLE : ST_READ;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign x_cur = c_reg - CW'(m_reg);
    assign y_cur = r_reg - RW'(n_reg);

    // horizontal pass over the last eleven pixels of the row
    always_comb
    begin
        logic [ACC_W-1:0] acc;
        logic [3:0] cmax, draw, d;
        logic [4:0] s;
        acc = ROUND_HALF;
        cmax = (c_reg >= CW'(LINES)) ? 4'(LINES) : c_reg[3:0];
        draw = 4'(m_reg) + 4'(HALF);
        for (int k = 0; k < TAPS; k++)
        begin
            d = (4'(k) > draw) ? 4'd0 : draw - 4'(k);
            if (d > cmax)
                d = cmax;
            s = (5'(c_slot_reg) >= 5'(d)) ? 5'(c_slot_reg) - 5'(d)
                                          : 5'(c_slot_reg) + 5'(TAPS) - 5'(d);
            acc = acc + ACC_W'(GAUSS_W[k]) * ACC_W'(win_reg[s[3:0]]);
        end
        hv = acc[23:16];
    end

    // row mod ten by reciprocal
    always_comb
    begin
        quot = (32'(r_reg) * DIV10_MUL) >> DIV10_SHIFT;
        row_slot = 4'(32'(r_reg) - ((quot << 3) + (quot << 1)));
    end

    // vertical pass: current row from hv, older rows from the line word
    always_comb
    begin
        logic [ACC_W-1:0] vacc;
        logic [3:0] rmax, eraw, e;
        logic [4:0] sl;
        logic [PIX_W-1:0] tap;
        vacc = ROUND_HALF;
        rmax = (r_reg >= RW'(LINES)) ? 4'(LINES) : r_reg[3:0];
        eraw = 4'(n_reg) + 4'(HALF);
        for (int k = 0; k < TAPS; k++)
        begin
            e = (4'(k) >= eraw) ? 4'd0 : eraw - 4'(k);
            if (e > rmax)
                e = rmax;
            sl = (slot_reg >= e) ? 5'(slot_reg) - 5'(e)
                                 : 5'(slot_reg) + 5'(LINES) - 5'(e);
            tap = (e == '0) ? hv_reg : rd_data_reg[sl[3:0]];
            vacc = vacc + ACC_W'(GAUSS_W[k]) * ACC_W'(tap);
        end
        vout = vacc[24] ? 8'hFF : vacc[23:16];
    end

    always_comb
    begin
        wr_row = rd_data_reg;
        wr_row[slot_reg] = hv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            line_mem[x_cur] <= wr_row;
        if (mem_rd_en)
            rd_data_reg <= line_mem[x_cur];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fw_reg <= FRAME_WIDTH_RESET;
            fh_reg <= FRAME_HEIGHT_RESET;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            win_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                win_reg[c_slot] <= pixel_in;
                if (c_end)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= r_end ? '0 : r_in + RW'(1);
                end
                else
                begin
                    col_cnt_reg <= c_in + CW'(1);
                    row_cnt_reg <= r_in;
                end
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c_reg <= c_in;
            r_reg <= r_in;
            c_slot_reg <= c_slot;
            c_end_reg <= c_end;
            r_end_reg <= r_end;
            have_y_reg <= r_end || r_ge;
            m_reg <= m_init;
            n_init_reg <= n_init;
        end
        if (state_reg == ST_READ)
        begin
            hv_reg <= hv;
            slot_reg <= row_slot;
            n_reg <= n_init_reg;
        end
        if (step && have_y_reg && (n_reg != '0))
            n_reg <= n_reg - 3'd1;
        if (x_done && (m_reg != '0))
            m_reg <= m_reg - 3'd1;
        if (emit)
        begin
            out_pix_reg <= vout;
            out_col_reg <= x_cur;
            out_row_reg <= y_cur;
            out_last_reg <= last_x && last_y;
            out_done_reg <= c_end_reg && r_end_reg && (m_reg == '0) && (n_reg == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign blurred_pixel = out_pix_reg;
    assign out_col = out_col_reg;
    assign out_row = out_row_reg;
    assign last_of_burst = out_last_reg;
    assign frame_done = out_done_reg;

endmodule
